FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");

// when ante holds, cons holds at the following edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/olar_pkg.sv
// ---------------------------------------------------------------------------
// olar_pkg
// types and defaults for the ordered list append/remove core
// ---------------------------------------------------------------------------
`default_nettype none

package olar_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_WORD_BITS = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [6:0]  count;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hw/rtl/ordered_list_append_remove_core.sv
// ---------------------------------------------------------------------------
// ordered_list_append_remove_core
// bounded ordered list of words held in one synchronous memory
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result on o_result, marked by o_strobe for one cycle, and the
// receiver cannot stall it. An append's result is registered and follows in
// the next cycle; busy stays low, so appends may be issued every cycle.
// Remove walks the memory through its single read port, one entry a cycle:
// a search from the head to the first match, then a read-ahead copy that
// moves each later entry one place forward. The copy carries on from where
// the search stopped, so each entry is read at most once; the result of a
// remove comes in the cycle busy drops, and the next command can be taken
// at the end of that cycle. A remove on an empty list answers at once.
// count reports the low 7 bits of the number of entries held.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ordered_list_append_remove_core
    import olar_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_data,
    output logic           o_strobe,
    output t_out_item      o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int KEEP  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int CW    = (CNT_W < 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_cidx;
    logic [CNT_W-1:0]       r_widx;
    logic                   r_pend;
    logic [WORD_BITS-1:0]   r_key;
    logic [WORD_BITS-1:0]   r_rdata;
    logic                   r_strobe;
    t_out_item              r_result;

    logic [WORD_BITS-1:0]   mem [CAPACITY];

    logic                   accept;
    logic [WORD_BITS-1:0]   key_in;
    logic                   issue;
    logic                   is_full;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic [AW-1:0]          rd_addr;
    logic [CNT_W-1:0]       n_count_up;
    logic [CNT_W-1:0]       n_count_dn;
    logic [CNT_W-1:0]       last_idx;

    function automatic logic [6:0] cnt7(input logic [CNT_W-1:0] c);
        return 7'(c[CW-1:0]);
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign key_in   = WORD_BITS'(i_data.value[KEEP-1:0]);
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign issue    = (r_state != S_IDLE) && (r_idx < r_count);
    assign rd_addr  = r_idx[AW-1:0];
    assign n_count_up = CNT_W'(r_count + 1'b1);
    assign n_count_dn = CNT_W'(r_count - 1'b1);
    assign last_idx   = n_count_dn;

    // memory write: append at the tail, or copy forward during shift
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = key_in;
        if (r_state == S_IDLE) begin
            mem_we = accept && (i_data.opcode == OP_APPEND) && !is_full;
        end else if (r_state == S_SHIFT) begin
            mem_we  = r_pend;
            wr_addr = r_widx[AW-1:0];
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_pend   <= issue;
            r_cidx   <= r_idx;
            if (issue) begin
                r_idx <= CNT_W'(r_idx + 1'b1);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_data.opcode == OP_APPEND) begin
                            r_strobe <= 1'b1;
                            if (is_full) begin
                                r_result.status <= ST_FULL;
                                r_result.count  <= cnt7(r_count);
                            end else begin
                                r_count         <= n_count_up;
                                r_result.status <= ST_DONE;
                                r_result.count  <= cnt7(n_count_up);
                            end
                        end else if (r_count == '0) begin
                            r_strobe        <= 1'b1;
                            r_result.status <= ST_EMPTY;
                            r_result.count  <= cnt7(r_count);
                        end else begin
                            r_key   <= key_in;
                            r_idx   <= '0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // compare the word read last cycle; the read issued now
                    // is the first copy source if this one matches
                    if (r_pend && (r_rdata == r_key)) begin
                        r_widx  <= r_cidx;
                        r_state <= S_SHIFT;
                    end else if (r_pend && (r_cidx == last_idx)) begin
                        r_strobe        <= 1'b1;
                        r_result.status <= ST_NOT_FOUND;
                        r_result.count  <= cnt7(r_count);
                        r_state         <= S_IDLE;
                    end
                end
                S_SHIFT: begin
                    if (r_pend) begin
                        r_widx <= CNT_W'(r_widx + 1'b1);
                    end
                    // last copy, if any, is written this cycle
                    if (!issue) begin
                        r_count         <= n_count_dn;
                        r_strobe        <= 1'b1;
                        r_result.status <= ST_DONE;
                        r_result.count  <= cnt7(n_count_dn);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ASSERT_AT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `ASSERT_AT(a_no_write_in_search, i_clk, i_rst_n, !((r_state == S_SEARCH) && mem_we))
    `ASSERT_NEXT(a_remove_goes_busy, i_clk, i_rst_n,
        accept && (i_data.opcode == OP_REMOVE) && (r_count != '0), busy && !o_strobe)
    `ASSERT_AT(a_count_step, i_clk, i_rst_n,
        !$past(i_rst_n) || (r_count == $past(r_count)) ||
        (r_count == CNT_W'($past(r_count) + 1'b1)) ||
        (CNT_W'(r_count + 1'b1) == $past(r_count)))
    `ASSERT_NEXT(a_shift_src_ahead, i_clk, i_rst_n,
        (r_state == S_SHIFT) && r_pend, r_widx <= r_count)

endmodule

`default_nettype wire
